// ===== hw/rtl/json_string_unescape_core_macros.svh =====
// assertion macros for the json string unescape core
// used by the rtl files that carry concurrent checks
`ifndef JSON_STRING_UNESCAPE_CORE_MACROS_SVH
`define JSON_STRING_UNESCAPE_CORE_MACROS_SVH

`ifndef SYNTH
`define JSU_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("jsu assertion failed");
`define JSU_ASSERT_CLK(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("jsu assertion failed");
`else
`define JSU_ASSERT(label, clk, rst, prop)
`define JSU_ASSERT_CLK(label, prop)
`endif

`endif

// ===== hw/rtl/jsu_pkg.sv =====
// shared types and constants of the json string unescape core
// no dependencies
package jsu_pkg;

   localparam int MAX_RESULTS     = 4;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic       CSR_IDX_STRIP = 1'b0;

   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
   localparam logic [7:0] CHAR_N         = 8'h6E;
   localparam logic [7:0] CHAR_T         = 8'h74;
   localparam logic [7:0] CHAR_U         = 8'h75;
   localparam logic [7:0] CHAR_LF        = 8'h0A;
   localparam logic [7:0] CHAR_TAB       = 8'h09;

   localparam logic [15:0] CODE_MIN_PRINT = 16'h0020;
   localparam logic [15:0] CODE_TWO_BYTE  = 16'h0080;
   localparam logic [15:0] CODE_THREE_BYTE = 16'h0800;
   localparam logic [7:0]  UTF8_LEAD2     = 8'hC0;
   localparam logic [7:0]  UTF8_LEAD3     = 8'hE0;
   localparam logic [7:0]  UTF8_CONT      = 8'h80;
   localparam logic [5:0]  UTF8_CONT_MASK = 6'h3F;

   typedef enum logic [1:0] {
      MODE_NORMAL,
      MODE_ESCAPE,
      MODE_HEX
   } esc_mode_type;

   typedef struct packed {
      logic [7:0] data;
      logic       valid;
      logic       err;
   } result_type;

   typedef struct packed {
      result_type [MAX_RESULTS-1:0] res;
      logic [1:0]                   cnt_m1;
      logic                         last;
   } entry_type;

endpackage

// ===== hw/rtl/jsu_front.sv =====
// front end: accepts input beats, tracks escapes, builds result entries
// depends on jsu_pkg
module jsu_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                strip_quotes,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,
   input  logic                req_tlast,
   input  logic                q_full,
   output logic                push,
   output jsu_pkg::entry_type  push_entry
);
   import jsu_pkg::*;

   function automatic logic [4:0] hex_digit(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, 4'(b - 8'h30)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r = {1'b1, 4'(b - 8'h57)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r = {1'b1, 4'(b - 8'h37)};
      end
      return r;
   endfunction

   esc_mode_type mode_ff, mode_in, mode_pre;
   logic [15:0]  hex_value_ff, hex_value_in, hv_pre, hv_shift;
   logic [2:0]   hex_count_ff, hex_count_in, hc_pre;
   logic         start_ff, start_in;
   logic         pass_ff, pass_in;
   logic         frame_ff, frame_in;

   logic         accept;
   logic [4:0]   digit;
   logic         is_quote, raw_path, drop, dec;
   logic         hex_hit, hex_done, hex_break, esc, norm;
   logic         code_en, byte_en;
   logic [15:0]  code_v;
   logic [7:0]   byte_v;
   result_type [2:0] code_res;
   logic [1:0]   ncode;
   logic [2:0]   total;
   result_type [MAX_RESULTS-1:0] res;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && !q_full;

   assign digit    = hex_digit(req_tdata);
   assign hv_shift = {hex_value_ff[11:0], digit[3:0]};
   assign is_quote = (req_tdata == CHAR_DQUOTE) || (req_tdata == CHAR_SQUOTE);
   assign raw_path = (start_ff && strip_quotes && !is_quote) || (!start_ff && pass_ff);
   assign drop     = (start_ff && strip_quotes && is_quote)
                   || (!start_ff && !pass_ff && frame_ff && req_tlast);
   assign dec       = !raw_path && !drop;
   assign hex_hit   = dec && (mode_ff == MODE_HEX) && digit[4];
   assign hex_done  = hex_hit && (hex_count_ff == 3'd3);
   assign hex_break = dec && (mode_ff == MODE_HEX) && !digit[4];
   assign esc       = dec && (mode_ff == MODE_ESCAPE);
   assign norm      = dec && ((mode_ff == MODE_NORMAL) || hex_break);

   // next state
   always_comb begin
      mode_pre = mode_ff;
      hv_pre   = hex_value_ff;
      hc_pre   = hex_count_ff;
      if (hex_hit) begin
         mode_pre = hex_done ? MODE_NORMAL : MODE_HEX;
         hv_pre   = hv_shift;
         hc_pre   = 3'(hex_count_ff + 3'd1);
      end else if (esc) begin
         if (req_tdata == CHAR_U) begin
            mode_pre = MODE_HEX;
            hv_pre   = 16'h0000;
            hc_pre   = 3'd0;
         end else begin
            mode_pre = MODE_NORMAL;
         end
      end else if (norm) begin
         mode_pre = (req_tdata == CHAR_BACKSLASH) ? MODE_ESCAPE : MODE_NORMAL;
      end

      if (req_tlast) begin
         mode_in      = MODE_NORMAL;
         hex_value_in = 16'h0000;
         hex_count_in = 3'd0;
         start_in     = 1'b1;
         pass_in      = 1'b0;
         frame_in     = 1'b0;
      end else begin
         mode_in      = mode_pre;
         hex_value_in = hv_pre;
         hex_count_in = hc_pre;
         start_in     = 1'b0;
         pass_in      = pass_ff || (start_ff && strip_quotes && !is_quote);
         frame_in     = start_ff ? strip_quotes : frame_ff;
      end
   end

   // outputs
   always_comb begin
      code_en = hex_done || hex_break || (req_tlast && (mode_pre == MODE_HEX));
      if (hex_done) begin
         code_v = hv_shift;
      end else if (hex_break) begin
         code_v = hex_value_ff;
      end else begin
         code_v = hv_pre;
      end
      byte_en = raw_path || (esc && (req_tdata != CHAR_U))
              || (norm && (req_tdata != CHAR_BACKSLASH));
      if (esc && (req_tdata == CHAR_N)) begin
         byte_v = CHAR_LF;
      end else if (esc && (req_tdata == CHAR_T)) begin
         byte_v = CHAR_TAB;
      end else begin
         byte_v = req_tdata;
      end

      code_res = '0;
      if (!code_en) begin
         ncode = 2'd0;
      end else if (code_v < CODE_MIN_PRINT) begin
         ncode       = 2'd1;
         code_res[0] = '{data: 8'h00, valid: 1'b0, err: 1'b1};
      end else if (code_v < CODE_TWO_BYTE) begin
         ncode       = 2'd1;
         code_res[0] = '{data: code_v[7:0], valid: 1'b1, err: 1'b0};
      end else if (code_v < CODE_THREE_BYTE) begin
         ncode       = 2'd2;
         code_res[0] = '{data: UTF8_LEAD2 | {3'b000, code_v[10:6]}, valid: 1'b1, err: 1'b0};
         code_res[1] = '{data: UTF8_CONT | {2'b00, code_v[5:0] & UTF8_CONT_MASK},
                         valid: 1'b1, err: 1'b0};
      end else begin
         ncode       = 2'd3;
         code_res[0] = '{data: UTF8_LEAD3 | {4'b0000, code_v[15:12]}, valid: 1'b1, err: 1'b0};
         code_res[1] = '{data: UTF8_CONT | {2'b00, code_v[11:6]}, valid: 1'b1, err: 1'b0};
         code_res[2] = '{data: UTF8_CONT | {2'b00, code_v[5:0] & UTF8_CONT_MASK},
                         valid: 1'b1, err: 1'b0};
      end

      for (int i = 0; i < MAX_RESULTS; i++) begin
         res[i] = '0;
         if (i < 3 && 2'(i) < ncode) begin
            res[i] = code_res[i];
         end else if (3'(i) == {1'b0, ncode} && byte_en) begin
            res[i] = '{data: byte_v, valid: 1'b1, err: 1'b0};
         end
      end

      total = 3'({1'b0, ncode} + {2'b00, byte_en});
      push_entry.res    = res;
      push_entry.last   = req_tlast;
      push_entry.cnt_m1 = (total == 3'd0) ? 2'd0 : 2'(total - 3'd1);
      push = accept && ((total != 3'd0) || req_tlast);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_NORMAL;
         hex_value_ff <= 16'h0000;
         hex_count_ff <= 3'd0;
         start_ff     <= 1'b1;
         pass_ff      <= 1'b0;
         frame_ff     <= 1'b0;
      end else if (accept) begin
         mode_ff      <= mode_in;
         hex_value_ff <= hex_value_in;
         hex_count_ff <= hex_count_in;
         start_ff     <= start_in;
         pass_ff      <= pass_in;
         frame_ff     <= frame_in;
      end
   end

endmodule

// ===== hw/rtl/jsu_queue.sv =====
// small entry queue between the front and back ends
// depends on jsu_pkg and json_string_unescape_core_macros.svh
`include "json_string_unescape_core_macros.svh"
module jsu_queue #(
   parameter int DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  jsu_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output jsu_pkg::entry_type head
);
   import jsu_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   entry_type         mem [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         count_in = CW'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   `JSU_ASSERT_CLK(a_no_overflow, push |-> !full || pop)
   `JSU_ASSERT_CLK(a_no_underflow, pop |-> head_valid)
   `JSU_ASSERT_CLK(a_count_tracks, push && !pop |=> count_ff == $past(count_ff) + 1'b1)

endmodule

// ===== hw/rtl/jsu_back.sv =====
// back end: walks queued entries and drives the result register
// depends on jsu_pkg and json_string_unescape_core_macros.svh
`include "json_string_unescape_core_macros.svh"
module jsu_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  jsu_pkg::entry_type head,
   output logic               pop,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [7:0]         out_byte,
   output logic               byte_valid,
   output logic               code_error,
   output logic               run_last,
   output logic               string_end
);
   import jsu_pkg::*;

   logic [1:0]  idx_ff;
   logic        valid_ff;
   logic [7:0]  byte_ff;
   logic        bvalid_ff, err_ff, run_last_ff, end_ff;
   logic        load, final_res;
   result_type  cur;

   assign load      = head_valid && (!valid_ff || rsp_ready);
   assign final_res = (idx_ff == head.cnt_m1);
   assign pop       = load && final_res;
   assign cur       = head.res[idx_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            idx_ff   <= final_res ? 2'd0 : 2'(idx_ff + 2'd1);
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff     <= cur.data;
         bvalid_ff   <= cur.valid;
         err_ff      <= cur.err;
         run_last_ff <= final_res;
         end_ff      <= final_res && head.last;
      end
   end

   assign rsp_valid  = valid_ff;
   assign out_byte   = byte_ff;
   assign byte_valid = bvalid_ff;
   assign code_error = err_ff;
   assign run_last   = run_last_ff;
   assign string_end = end_ff;

   `JSU_ASSERT(a_idx_in_range, clock, reset, head_valid |-> idx_ff <= head.cnt_m1)
   `JSU_ASSERT(a_end_is_run_last, clock, reset, valid_ff && end_ff |-> run_last_ff)
   `JSU_ASSERT(a_err_no_byte, clock, reset, valid_ff && err_ff |-> !bvalid_ff && byte_ff == 8'h00)
   `JSU_ASSERT(a_pop_rewinds, clock, reset, pop |=> idx_ff == 2'd0)

endmodule

// ===== hw/rtl/json_string_unescape_core.sv =====
// json string unescaper, top level
// depends on jsu_pkg, jsu_front, jsu_queue, jsu_back
//
// req channel: one raw string byte per beat (tdata), tlast on the final byte.
// rsp channel: decoded results; tdata = out_byte and run_last, tuser = byte_valid
// and code_error, tlast = string_end. a beat may yield zero to four results; a
// beat that yields none and is not last gives no rsp beat.
// csr port: register strip_quotes at byte address 0, written on the access cycle;
// it takes effect at the first byte of the next string.
// the first result of a beat passes through the entry queue and then the result
// register before it is on rsp. throughput: one req beat per cycle while each beat
// yields at most one result and rsp does not stall; the back end hands out a beat's
// results one rsp beat at a time, and the entry queue (QUEUE_DEPTH entries)
// absorbs the difference before req_tready drops.
// rsp stall: the result register holds its beat, the queue fills, then req_tready
// goes low; no result is lost or repeated.
// reset: synchronous, clears the escape state, the queue and the result register;
// strip_quotes returns to 0.
module json_string_unescape_core #(
   parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_byte, [8] run_last, [15:9] zero
   output logic [1:0]  rsp_tuser,   // [0] byte_valid, [1] code_error
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import jsu_pkg::*;

   logic       strip_ff;
   logic       csr_wr;
   logic       push, full, pop, head_valid;
   entry_type  push_entry, head;
   logic [7:0] out_byte;
   logic       byte_valid, code_error, run_last, string_end;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == CSR_IDX_STRIP);
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_STRIP) ? {31'd0, strip_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         strip_ff <= 1'b0;
      end else if (csr_wr) begin
         strip_ff <= csr_pwdata[0];
      end
   end

   jsu_front u_front (
      .clock        (clock),
      .reset        (reset),
      .strip_quotes (strip_ff),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .q_full       (full),
      .push         (push),
      .push_entry   (push_entry)
   );

   jsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   jsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_ready  (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .out_byte   (out_byte),
      .byte_valid (byte_valid),
      .code_error (code_error),
      .run_last   (run_last),
      .string_end (string_end)
   );

   assign rsp_tdata = {7'd0, run_last, out_byte};
   assign rsp_tuser = {code_error, byte_valid};
   assign rsp_tlast = string_end;

endmodule

// ===== tb/jsu_unescape_checker.sv =====
// result checker for the json string unescape core: watches req, rsp and csr,
// predicts the decoded results of each req beat and compares them in order
// depends on jsu_pkg
module jsu_unescape_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // [7:0] out_byte, [8] run_last, [15:9] zero
   input  logic [1:0]  rsp_tuser,   // [0] byte_valid, [1] code_error
   input  logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic [31:0] csr_prdata,
   input  logic        csr_pready,
   output int          pending_results,
   output int          fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import jsu_pkg::*;

   localparam logic [2:0] STRIP_ADDR = 3'(4 * CSR_IDX_STRIP);

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       code_error;
      logic       run_last;
      logic       string_end;
   } decoded_result_type;

   decoded_result_type expected_results[$];
   decoded_result_type beat_buf[MAX_RESULTS];
   int                 beat_count;

   logic         strip_reg;
   logic         strip_latched;
   esc_mode_type esc_mode;
   logic [15:0]  hex_acc;
   logic [2:0]   hex_digits;
   logic         at_start;
   logic         raw_copy;

   task automatic add_result(input logic [7:0] b, input logic valid, input logic err);
      beat_buf[beat_count] = '{b, valid, err, 1'b0, 1'b0};
      beat_count++;
   endtask

   task automatic clear_string();
      esc_mode      = MODE_NORMAL;
      hex_acc       = '0;
      hex_digits    = '0;
      at_start      = 1'b1;
      raw_copy      = 1'b0;
      strip_latched = 1'b0;
   endtask

   task automatic add_code_point(input logic [15:0] v);
      if (v < CODE_MIN_PRINT) begin
         add_result(8'h00, 1'b0, 1'b1);
      end else if (v < CODE_TWO_BYTE) begin
         add_result(v[7:0], 1'b1, 1'b0);
      end else if (v < CODE_THREE_BYTE) begin
         add_result(UTF8_LEAD2 | 8'(v >> 6), 1'b1, 1'b0);
         add_result(UTF8_CONT | {2'b00, v[5:0] & UTF8_CONT_MASK}, 1'b1, 1'b0);
      end else begin
         add_result(UTF8_LEAD3 | 8'(v >> 12), 1'b1, 1'b0);
         add_result(UTF8_CONT | {2'b00, v[11:6] & UTF8_CONT_MASK}, 1'b1, 1'b0);
         add_result(UTF8_CONT | {2'b00, v[5:0] & UTF8_CONT_MASK}, 1'b1, 1'b0);
      end
   endtask

   function automatic int hex_nibble(input logic [7:0] b);
      if (b >= "0" && b <= "9") return int'(b - "0");
      if (b >= "a" && b <= "f") return int'(b - "a") + 10;
      if (b >= "A" && b <= "F") return int'(b - "A") + 10;
      return -1;
   endfunction

   task automatic decode_char(input logic [7:0] b);
      int d;
      if (esc_mode == MODE_HEX) begin
         d = hex_nibble(b);
         if (d >= 0) begin
            hex_acc    = {hex_acc[11:0], 4'(d)};
            hex_digits = hex_digits + 3'd1;
            if (hex_digits >= 3'd4) begin
               add_code_point(hex_acc);
               esc_mode = MODE_NORMAL;
            end
            return;
         end
         add_code_point(hex_acc);
         esc_mode = MODE_NORMAL;
      end
      if (esc_mode == MODE_ESCAPE) begin
         esc_mode = MODE_NORMAL;
         case (b)
            CHAR_N: add_result(CHAR_LF, 1'b1, 1'b0);
            CHAR_T: add_result(CHAR_TAB, 1'b1, 1'b0);
            CHAR_U: begin
               esc_mode   = MODE_HEX;
               hex_acc    = '0;
               hex_digits = '0;
            end
            default: add_result(b, 1'b1, 1'b0);
         endcase
         return;
      end
      if (b == CHAR_BACKSLASH) esc_mode = MODE_ESCAPE;
      else add_result(b, 1'b1, 1'b0);
   endtask

   task automatic predict_beat(input logic [7:0] b, input logic last);
      beat_count = 0;
      if (at_start) begin
         at_start      = 1'b0;
         strip_latched = strip_reg;
         if (strip_latched) begin
            if (b != CHAR_DQUOTE && b != CHAR_SQUOTE) begin
               raw_copy = 1'b1;
               add_result(b, 1'b1, 1'b0);
            end
         end else begin
            decode_char(b);
         end
      end else if (raw_copy) begin
         add_result(b, 1'b1, 1'b0);
      end else if (!(strip_latched && last)) begin
         decode_char(b);
      end
      if (last) begin
         if (esc_mode == MODE_HEX) add_code_point(hex_acc);
         clear_string();
         if (beat_count == 0) add_result(8'h00, 1'b0, 1'b0);
         beat_buf[beat_count-1].string_end = 1'b1;
      end
      if (beat_count > 0) beat_buf[beat_count-1].run_last = 1'b1;
      for (int i = 0; i < beat_count; i++) expected_results.push_back(beat_buf[i]);
   endtask

   task automatic check_result();
      decoded_result_type got;
      decoded_result_type want;
      got = '{rsp_tdata[7:0], rsp_tuser[0], rsp_tuser[1], rsp_tdata[8], rsp_tlast};
      if (expected_results.size() == 0) begin
         fail_count++;
         $display("%0t: unexpected rsp beat byte %02h valid %0b err %0b run_last %0b end %0b",
                  $realtime, got.out_byte, got.byte_valid, got.code_error, got.run_last,
                  got.string_end);
         return;
      end
      want = expected_results.pop_front();
      if (got !== want) begin
         fail_count++;
         $display({"%0t: rsp mismatch, expected byte %02h valid %0b err %0b run_last %0b ",
                   "end %0b, got byte %02h valid %0b err %0b run_last %0b end %0b"},
                  $realtime, want.out_byte, want.byte_valid, want.code_error, want.run_last,
                  want.string_end, got.out_byte, got.byte_valid, got.code_error,
                  got.run_last, got.string_end);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         strip_reg = 1'b0;
         clear_string();
         expected_results.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr == STRIP_ADDR) strip_reg = csr_pwdata[0];
            end else if (csr_paddr == STRIP_ADDR && csr_prdata !== {31'b0, strip_reg}) begin
               fail_count++;
               $display("%0t: csr readback mismatch, expected %08h, got %08h",
                        $realtime, {31'b0, strip_reg}, csr_prdata);
            end
         end
         if (req_tvalid && req_tready) predict_beat(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) check_result();
      end
      pending_results = expected_results.size();
   end

endmodule

// ===== tb/tb.sv =====
// testbench top for the json string unescape core: clock, reset, csr setup,
// directed and random strings on req with random idling on both sides
// depends on jsu_pkg, json_string_unescape_core and jsu_unescape_checker
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import jsu_pkg::*;

   localparam int         CYCLE_LIMIT  = 300000;
   localparam int         DRAIN_CYCLES = 24;
   localparam int         TOTAL_ITEMS  = 410;
   localparam logic [2:0] STRIP_ADDR   = 3'(4 * CSR_IDX_STRIP);

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int          pending_results;
   int          fail_count;
   int          cycle_count = 0;
   int          items_sent = 0;
   bit          req_idle_on = 1'b1;
   bit          rsp_idle_on = 1'b1;
   bit          rsp_fire = 1'b0;
   int          rsp_wait = 0;
   logic [7:0]  text[$];

   json_string_unescape_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   jsu_unescape_checker result_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready),
      .pending_results (pending_results),
      .fail_count      (fail_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // rsp side: random wait before taking each beat
   always @(posedge clock) rsp_fire <= rsp_tvalid && rsp_tready;

   always @(negedge clock) begin
      if (rsp_fire) rsp_wait = rsp_idle_on ? $urandom_range(0, 9) : 0;
      if (rsp_wait > 0) begin
         rsp_tready <= 1'b0;
         rsp_wait--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_text();
      for (int i = 0; i < text.size(); i++) send_byte(text[i], i == text.size() - 1);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // write the strip register, then read it back
   task automatic set_strip(input logic v);
      wait_idle();
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr  <= STRIP_ADDR;
      csr_pwdata <= {31'b0, v};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) return "0" + 8'(v);
      if ($urandom_range(0, 1) == 0) return "a" + 8'(v - 4'd10);
      return "A" + 8'(v - 4'd10);
   endfunction

   task automatic build_random_text(input logic strip);
      int         tokens;
      int         digits;
      bit         quoted;
      logic [7:0] c;
      text.delete();
      quoted = strip && ($urandom_range(0, 4) != 0);
      if (quoted) text.push_back($urandom_range(0, 1) ? CHAR_DQUOTE : CHAR_SQUOTE);
      tokens = $urandom_range(0, 6);
      repeat (tokens) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               c = 8'($urandom_range(8'h20, 8'h7E));
               text.push_back(c == CHAR_BACKSLASH ? "_" : c);
            end
            3: begin
               text.push_back(CHAR_BACKSLASH);
               text.push_back($urandom_range(0, 1) ? CHAR_N : CHAR_T);
            end
            4: begin
               text.push_back(CHAR_BACKSLASH);
               text.push_back(8'($urandom_range(0, 255)));
            end
            5, 6, 7: begin
               text.push_back(CHAR_BACKSLASH);
               text.push_back(CHAR_U);
               digits = $urandom_range(0, 2) == 0 ? 4 : $urandom_range(1, 4);
               repeat (digits) text.push_back(hex_char(4'($urandom_range(0, 15))));
            end
            8: text.push_back(8'($urandom_range(0, 255)));
            default: text.push_back(CHAR_BACKSLASH);
         endcase
      end
      if (quoted) begin
         if ($urandom_range(0, 9) == 0) text.push_back(8'($urandom_range(0, 255)));
         else text.push_back(text[0]);
      end
      if (text.size() == 0) text.push_back(8'($urandom_range(0, 255)));
   endtask

   initial begin
      int   phase;
      logic phase_strip;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_strip(1'b0);
      text = {CHAR_BACKSLASH, CHAR_N, CHAR_BACKSLASH, CHAR_T, CHAR_BACKSLASH, CHAR_U,
              "a", "b", "C", "d", CHAR_BACKSLASH, CHAR_BACKSLASH};
      send_text();
      text = {CHAR_BACKSLASH, CHAR_U, "1", "2", "3", "z"};
      send_text();
      text = {CHAR_BACKSLASH, CHAR_U, "1", "f"};
      send_text();
      text = {CHAR_BACKSLASH};
      send_text();
      set_strip(1'b1);
      text = {"x", CHAR_BACKSLASH};
      send_text();
      text = {CHAR_SQUOTE, CHAR_BACKSLASH, CHAR_U, "4", CHAR_SQUOTE};
      send_text();

      phase = 0;
      while (items_sent < TOTAL_ITEMS) begin
         if (phase < 2) phase_strip = phase[0];
         else phase_strip = 1'($urandom_range(0, 1));
         set_strip(phase_strip);
         repeat ($urandom_range(4, 10)) begin
            if (items_sent < TOTAL_ITEMS) begin
               req_idle_on = $urandom_range(0, 3) != 0;
               rsp_idle_on = $urandom_range(0, 3) != 0;
               build_random_text(phase_strip);
               send_text();
            end
         end
         phase++;
      end

      wait_idle();
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/jsu_pkg.sv
hw/rtl/jsu_front.sv
hw/rtl/jsu_queue.sv
hw/rtl/jsu_back.sv
hw/rtl/json_string_unescape_core.sv
tb/jsu_unescape_checker.sv
tb/tb.sv
